FILE: hdl/coap_pkg.sv
// Shared types and constants for the CoAP request header parser.
// Holds the transfer payload structs, the parse phase enum and protocol constants.
// Depends on nothing.
package coap_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } req_t;

    typedef struct packed {
        logic [1:0]  parse_status;
        logic [1:0]  msg_type;
        logic [3:0]  token_length;
        logic [15:0] message_id;
        logic [63:0] token_value;
        logic        is_status;
    } res_t;

    typedef enum logic [3:0] {
        PH_HDR     = 4'd0,
        PH_TOKEN   = 4'd1,
        PH_OPT     = 4'd2,
        PH_D1      = 4'd3,
        PH_D2H     = 4'd4,
        PH_D2L     = 4'd5,
        PH_L1      = 4'd6,
        PH_L2H     = 4'd7,
        PH_L2L     = 4'd8,
        PH_VALUE   = 4'd9,
        PH_PAYLOAD = 4'd10
    } phase_t;

    localparam logic [1:0]  STATUS_GET       = 2'd0;
    localparam logic [1:0]  STATUS_OTHER     = 2'd1;
    localparam logic [1:0]  STATUS_MALFORMED = 2'd2;

    localparam logic [1:0]  COAP_VERSION     = 2'd1;
    localparam logic [7:0]  CODE_GET         = 8'h01;
    localparam logic [7:0]  PAYLOAD_MARKER   = 8'hFF;
    localparam logic [3:0]  NIB_EXT8         = 4'd13;
    localparam logic [3:0]  NIB_EXT16        = 4'd14;
    localparam logic [16:0] EXT8_BASE        = 17'd13;
    localparam logic [16:0] EXT16_BASE       = 17'd269;
    localparam logic [15:0] OPT_URI_PATH     = 16'd11;
    localparam logic [16:0] SHORT_SEG_MAX    = 17'd7;
    localparam logic [3:0]  TOKEN_MAX        = 4'd8;
    localparam logic [7:0]  CHAR_S           = 8'h73;

endpackage

FILE: hdl/coap_request_header_parser.sv
// Top level of the CoAP request header parser: input register, parse logic, result register.
// Depends on coap_pkg for the transfer structs, the phase enum and protocol constants.
//
// The parser takes one datagram byte per clock cycle and never stalls its input except
// when a final byte arrives while the previous result still waits in the result register.
// Each byte passes through the input register and combinational header and option decoding,
// and the result for a datagram is loaded into the result register when its last byte is
// taken from the input register, which waits while the previous result is still stalled. Bytes
// beyond MAX_PACKET are ignored, and a result is produced only for a byte marked as last.
module coap_request_header_parser
    import coap_pkg::*;
#(
    parameter int MAX_PACKET = 256
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req_item,
    output logic res_valid,
    input  logic res_stall,
    output res_t res_item
);

    localparam int PW = $clog2(MAX_PACKET + 1);

    logic        in_valid_reg;
    req_t        in_item_reg;
    logic        in_fire;
    logic        out_free;

    logic        out_valid_reg;
    res_t        out_item_reg;

    logic [PW-1:0] pos_reg,    pos_next;
    phase_t        phase_reg,  phase_next;
    logic [1:0]    type_reg,   type_next;
    logic [3:0]    tlen_reg,   tlen_next;
    logic [7:0]    code_reg,   code_next;
    logic [15:0]   msgid_reg,  msgid_next;
    logic [63:0]   token_reg,  token_next;
    logic [15:0]   optnum_reg, optnum_next;
    logic [7:0]    ext_reg,    ext_next;
    logic [16:0]   remain_reg, remain_next;
    logic          is_s_reg,   is_s_next;
    logic          err_reg,    err_next;
    logic          seg_reg,    seg_next;

    res_t          result;

    assign out_free  = !out_valid_reg || !res_stall;
    assign in_fire   = in_valid_reg && (!in_item_reg.last_byte || out_free);
    assign req_stall = in_valid_reg && !in_fire;
    assign res_valid = out_valid_reg;
    assign res_item  = out_item_reg;

    always_comb
    begin
        logic [7:0]  b;
        logic [3:0]  nib;
        logic [16:0] dlt;
        logic [16:0] len;
        logic        do_delta;
        logic        do_len;
        logic [2:0]  idx;
        logic        ok;

        b        = in_item_reg.data_byte;
        nib      = remain_reg[3:0];
        dlt      = '0;
        len      = '0;
        do_delta = 1'b0;
        do_len   = 1'b0;
        idx      = pos_reg[2:0] ^ 3'd4;
        ok       = 1'b0;

        pos_next    = pos_reg;
        phase_next  = phase_reg;
        type_next   = type_reg;
        tlen_next   = tlen_reg;
        code_next   = code_reg;
        msgid_next  = msgid_reg;
        token_next  = token_reg;
        optnum_next = optnum_reg;
        ext_next    = ext_reg;
        remain_next = remain_reg;
        is_s_next   = is_s_reg;
        err_next    = err_reg;
        seg_next    = seg_reg;

        if (pos_reg < PW'(MAX_PACKET))
        begin
            pos_next = pos_reg + PW'(1);
            if (!err_reg)
            begin
                case (phase_reg)
                    PH_HDR:
                    begin
                        if (pos_reg == PW'(0))
                        begin
                            if (b[7:6] != COAP_VERSION)
                            begin
                                err_next = 1'b1;
                            end
                            else
                            begin
                                type_next = b[5:4];
                                tlen_next = b[3:0];
                                if (b[3:0] > TOKEN_MAX)
                                begin
                                    err_next = 1'b1;
                                end
                            end
                        end
                        else if (pos_reg == PW'(1))
                        begin
                            code_next = b;
                        end
                        else if (pos_reg == PW'(2))
                        begin
                            msgid_next = {b, 8'h00};
                        end
                        else
                        begin
                            msgid_next = {msgid_reg[15:8], b};
                            phase_next = (tlen_reg == 4'd0) ? PH_OPT : PH_TOKEN;
                        end
                    end
                    PH_TOKEN:
                    begin
                        token_next = token_reg | ({b, 56'h0} >> {idx, 3'b000});
                        if ((pos_reg - PW'(3)) >= PW'(tlen_reg))
                        begin
                            phase_next = PH_OPT;
                        end
                    end
                    PH_OPT:
                    begin
                        if (b == PAYLOAD_MARKER)
                        begin
                            phase_next = PH_PAYLOAD;
                        end
                        else
                        begin
                            remain_next = {13'd0, b[3:0]};
                            nib         = b[3:0];
                            if (b[7:4] == NIB_EXT8)
                            begin
                                phase_next = PH_D1;
                            end
                            else if (b[7:4] == NIB_EXT16)
                            begin
                                phase_next = PH_D2H;
                            end
                            else
                            begin
                                do_delta = 1'b1;
                                dlt      = {13'd0, b[7:4]};
                            end
                        end
                    end
                    PH_D1:
                    begin
                        do_delta = 1'b1;
                        dlt      = EXT8_BASE + {9'd0, b};
                    end
                    PH_D2H:
                    begin
                        ext_next   = b;
                        phase_next = PH_D2L;
                    end
                    PH_D2L:
                    begin
                        do_delta = 1'b1;
                        dlt      = EXT16_BASE + {1'b0, ext_reg, b};
                    end
                    PH_L1:
                    begin
                        do_len = 1'b1;
                        len    = EXT8_BASE + {9'd0, b};
                    end
                    PH_L2H:
                    begin
                        ext_next   = b;
                        phase_next = PH_L2L;
                    end
                    PH_L2L:
                    begin
                        do_len = 1'b1;
                        len    = EXT16_BASE + {1'b0, ext_reg, b};
                    end
                    PH_VALUE:
                    begin
                        if (seg_reg)
                        begin
                            is_s_next = (b == CHAR_S);
                            seg_next  = 1'b0;
                        end
                        remain_next = remain_reg - 17'd1;
                        if (remain_reg == 17'd1)
                        begin
                            phase_next = PH_OPT;
                        end
                    end
                    default:
                    begin
                        phase_next = phase_reg;
                    end
                endcase

                if (do_delta)
                begin
                    optnum_next = optnum_reg + dlt[15:0];
                    if (nib == NIB_EXT8)
                    begin
                        phase_next = PH_L1;
                    end
                    else if (nib == NIB_EXT16)
                    begin
                        phase_next = PH_L2H;
                    end
                    else
                    begin
                        do_len = 1'b1;
                        len    = {13'd0, nib};
                    end
                end

                if (do_len)
                begin
                    remain_next = len;
                    seg_next    = (optnum_next == OPT_URI_PATH) && (len >= 17'd1)
                                  && (len <= SHORT_SEG_MAX);
                    phase_next  = (len != 17'd0) ? PH_VALUE : PH_OPT;
                end
            end
        end

        ok = !err_next && ((phase_next == PH_OPT) || (phase_next == PH_PAYLOAD));
        result = '0;
        if (ok)
        begin
            result.parse_status = (code_next == CODE_GET) ? STATUS_GET : STATUS_OTHER;
            result.msg_type     = type_next;
            result.token_length = tlen_next;
            result.message_id   = msgid_next;
            result.token_value  = token_next;
            result.is_status    = is_s_next;
        end
        else
        begin
            result.parse_status = STATUS_MALFORMED;
        end

        if (in_item_reg.last_byte)
        begin
            pos_next    = '0;
            phase_next  = PH_HDR;
            type_next   = '0;
            tlen_next   = '0;
            code_next   = '0;
            msgid_next  = '0;
            token_next  = '0;
            optnum_next = '0;
            ext_next    = '0;
            remain_next = '0;
            is_s_next   = 1'b0;
            err_next    = 1'b0;
            seg_next    = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            in_item_reg  <= '0;
        end
        else if (!req_stall)
        begin
            in_valid_reg <= req_valid;
            if (req_valid)
            begin
                in_item_reg <= req_item;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            phase_reg  <= PH_HDR;
            type_reg   <= '0;
            tlen_reg   <= '0;
            code_reg   <= '0;
            msgid_reg  <= '0;
            token_reg  <= '0;
            optnum_reg <= '0;
            ext_reg    <= '0;
            remain_reg <= '0;
            is_s_reg   <= 1'b0;
            err_reg    <= 1'b0;
            seg_reg    <= 1'b0;
        end
        else if (in_fire)
        begin
            pos_reg    <= pos_next;
            phase_reg  <= phase_next;
            type_reg   <= type_next;
            tlen_reg   <= tlen_next;
            code_reg   <= code_next;
            msgid_reg  <= msgid_next;
            token_reg  <= token_next;
            optnum_reg <= optnum_next;
            ext_reg    <= ext_next;
            remain_reg <= remain_next;
            is_s_reg   <= is_s_next;
            err_reg    <= err_next;
            seg_reg    <= seg_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            out_item_reg  <= '0;
        end
        else if (in_fire && in_item_reg.last_byte)
        begin
            out_valid_reg <= 1'b1;
            out_item_reg  <= result;
        end
        else if (!res_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

endmodule
